FILE: hdl/sh816_pkg.sv
// Shared types, codes and default sizes for the symbol histogram block.
package sh816_pkg;

    localparam int MAX_SYMBOLS_DEF = 65536;
    localparam int COUNT_BITS_DEF  = 32;
    localparam int QUEUE_DEPTH     = 4;

    localparam int BYTE_W    = 8;
    localparam int SYMBOL_W  = 16;
    localparam int REQ_W     = 2;
    localparam int COUNT_O_W = 32;

    localparam logic [REQ_W-1:0] REQ_DATA = 2'd0;
    localparam logic [REQ_W-1:0] REQ_END  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_READ = 2'd2;

    localparam logic OP_BUMP = 1'b0;
    localparam logic OP_READ = 1'b1;

    typedef struct packed {
        logic                kind;
        logic                in_range;
        logic [SYMBOL_W-1:0] symbol;
    } op_t;

endpackage

FILE: hdl/symbol_histogram_8_16_top.sv
// Top level of the symbol histogram: command port, mode register, front end, queue, count engine.
//
// After reset the block sweeps its count memory to zero, one entry per cycle, and keeps
// busy high until all MAX_SYMBOLS entries (65536 by default) are cleared. Commands are taken
// whenever busy is low; the front end takes one command per cycle into a four-entry queue, and
// the count engine retires queued operations one at a time (memory read, then write or result),
// while first bytes of a pair, empty ends of stream and unused codes are never queued. A read
// result appears on result_valid with symbol_count and count_symbol for exactly one cycle,
// rising once the engine has taken its command from the queue head into its operation
// register and then registered the result; the receiver cannot stall it.
// The user must write the mode register through cfg_valid/cfg_ready only while no command
// is in flight; the block itself does not enforce it.
module symbol_histogram_8_16_top
    import sh816_pkg::*;
#(
    parameter int MAX_SYMBOLS = MAX_SYMBOLS_DEF,
    parameter int COUNT_BITS  = COUNT_BITS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [REQ_W-1:0]     req_type,
    input  logic [BYTE_W-1:0]    data_byte,
    input  logic [SYMBOL_W-1:0]  read_symbol,
    output logic                 result_valid,
    output logic [COUNT_O_W-1:0] symbol_count,
    output logic [SYMBOL_W-1:0]  count_symbol,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic                 cfg_data
);

    logic accept;
    logic push;
    op_t  push_op;
    op_t  head_op;
    logic q_empty;
    logic q_full;
    logic q_pop;
    logic clearing;

    assign busy      = clearing || q_full;
    assign accept    = start && !busy;
    assign cfg_ready = 1'b1;

    sh816_front #(
        .MAX_SYMBOLS (MAX_SYMBOLS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .req_type    (req_type),
        .data_byte   (data_byte),
        .read_symbol (read_symbol),
        .cfg_write   (cfg_valid && cfg_ready),
        .cfg_data    (cfg_data),
        .push        (push),
        .op          (push_op)
    );

    sh816_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .push_op (push_op),
        .pop     (q_pop),
        .head_op (head_op),
        .empty   (q_empty),
        .full    (q_full)
    );

    sh816_back #(
        .MAX_SYMBOLS (MAX_SYMBOLS),
        .COUNT_BITS  (COUNT_BITS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_empty      (q_empty),
        .q_head       (head_op),
        .q_pop        (q_pop),
        .clearing     (clearing),
        .result_valid (result_valid),
        .symbol_count (symbol_count),
        .count_symbol (count_symbol)
    );

endmodule

FILE: hdl/sh816_front.sv
// Front end: accepts commands, pairs bytes and classifies them into count or read operations.
module sh816_front
    import sh816_pkg::*;
#(
    parameter int MAX_SYMBOLS = MAX_SYMBOLS_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  logic [REQ_W-1:0]    req_type,
    input  logic [BYTE_W-1:0]   data_byte,
    input  logic [SYMBOL_W-1:0] read_symbol,
    input  logic                cfg_write,
    input  logic                cfg_data,
    output logic                push,
    output op_t                 op
);

    localparam logic [SYMBOL_W:0] SYM_LIMIT = (SYMBOL_W+1)'(MAX_SYMBOLS);

    logic                mode_reg;
    logic                pend_valid_reg;
    logic                pend_valid_next;
    logic [BYTE_W-1:0]   pend_byte_reg;
    logic [BYTE_W-1:0]   pend_byte_next;
    logic                want;
    logic [SYMBOL_W-1:0] sym;
    logic                kind;
    logic                in_range;

    always_comb
    begin
        pend_valid_next = pend_valid_reg;
        pend_byte_next  = pend_byte_reg;
        want            = 1'b0;
        kind            = OP_BUMP;
        sym             = '0;
        case (req_type)
            REQ_DATA:
            begin
                if (!mode_reg)
                begin
                    want = 1'b1;
                    sym  = {{(SYMBOL_W-BYTE_W){1'b0}}, data_byte};
                end
                else if (pend_valid_reg)
                begin
                    want            = 1'b1;
                    sym             = {pend_byte_reg, data_byte};
                    pend_valid_next = 1'b0;
                    pend_byte_next  = '0;
                end
                else
                begin
                    pend_valid_next = 1'b1;
                    pend_byte_next  = data_byte;
                end
            end
            REQ_END:
            begin
                if (pend_valid_reg)
                begin
                    want            = 1'b1;
                    sym             = {{(SYMBOL_W-BYTE_W){1'b0}}, pend_byte_reg};
                    pend_valid_next = 1'b0;
                    pend_byte_next  = '0;
                end
            end
            REQ_READ:
            begin
                want = 1'b1;
                kind = OP_READ;
                sym  = read_symbol;
            end
            default:
            begin
                want = 1'b0;
            end
        endcase
        in_range    = ({1'b0, sym} < SYM_LIMIT);
        push        = accept && want && (in_range || (kind == OP_READ));
        op.kind     = kind;
        op.in_range = in_range;
        op.symbol   = sym;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= 1'b0;
            pend_valid_reg <= 1'b0;
            pend_byte_reg  <= '0;
        end
        else
        begin
            if (cfg_write)
            begin
                mode_reg <= cfg_data;
            end
            if (accept)
            begin
                pend_valid_reg <= pend_valid_next;
                pend_byte_reg  <= pend_byte_next;
            end
        end
    end

endmodule

FILE: hdl/sh816_queue.sv
// Short operation queue between the front end and the count engine.
module sh816_queue
    import sh816_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  op_t  push_op,
    input  logic pop,
    output op_t  head_op,
    output logic empty,
    output logic full
);

    localparam int PW = $clog2(QUEUE_DEPTH);

    op_t           slot_reg [QUEUE_DEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] rd_ptr_reg;
    logic [PW:0]   fill_reg;
    logic [PW:0]   fill_next;

    assign empty   = (fill_reg == '0);
    assign full    = (fill_reg == (PW+1)'(QUEUE_DEPTH));
    assign head_op = slot_reg[rd_ptr_reg];

    always_comb
    begin
        fill_next = fill_reg;
        if (push && !pop)
        begin
            fill_next = fill_reg + (PW+1)'(1);
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - (PW+1)'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_op;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + PW'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + PW'(1);
            end
            fill_reg <= fill_next;
        end
    end

endmodule

FILE: hdl/sh816_back.sv
// Count engine: clears the count memory after reset, then runs read-modify-write and reads.
module sh816_back
    import sh816_pkg::*;
#(
    parameter int MAX_SYMBOLS = MAX_SYMBOLS_DEF,
    parameter int COUNT_BITS  = COUNT_BITS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 q_empty,
    input  op_t                  q_head,
    output logic                 q_pop,
    output logic                 clearing,
    output logic                 result_valid,
    output logic [COUNT_O_W-1:0] symbol_count,
    output logic [SYMBOL_W-1:0]  count_symbol
);

    localparam int AW = $clog2(MAX_SYMBOLS);
    localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_SYMBOLS - 1);

    localparam logic [1:0] ST_CLEAR  = 2'd0;
    localparam logic [1:0] ST_IDLE   = 2'd1;
    localparam logic [1:0] ST_ACCESS = 2'd2;

    logic [COUNT_BITS-1:0] count_mem [MAX_SYMBOLS];
    logic [COUNT_BITS-1:0] rd_data_reg;

    logic [1:0]           state_reg;
    logic [1:0]           state_next;
    logic [AW-1:0]        clr_addr_reg;
    op_t                  op_reg;
    logic                 res_valid_reg;
    logic [COUNT_O_W-1:0] res_count_reg;
    logic [SYMBOL_W-1:0]  res_sym_reg;

    logic                  mem_we;
    logic [AW-1:0]         mem_wa;
    logic [COUNT_BITS-1:0] mem_wd;
    logic [AW-1:0]         mem_ra;
    logic [63:0]           wide_count;
    logic [COUNT_O_W-1:0]  sat_count;

    assign clearing     = (state_reg == ST_CLEAR);
    assign q_pop        = (state_reg == ST_IDLE) && !q_empty;
    assign mem_ra       = q_head.symbol[AW-1:0];
    assign wide_count   = 64'(rd_data_reg);
    assign sat_count    = (wide_count[63:32] != '0) ? '1 : wide_count[31:0];
    assign result_valid = res_valid_reg;
    assign symbol_count = res_count_reg;
    assign count_symbol = res_sym_reg;

    always_comb
    begin
        state_next = state_reg;
        mem_we     = 1'b0;
        mem_wa     = op_reg.symbol[AW-1:0];
        mem_wd     = (rd_data_reg == '1) ? rd_data_reg : rd_data_reg + COUNT_BITS'(1);
        case (state_reg)
            ST_CLEAR:
            begin
                mem_we = 1'b1;
                mem_wa = clr_addr_reg;
                mem_wd = '0;
                if (clr_addr_reg == LAST_ADDR)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (!q_empty)
                begin
                    state_next = ST_ACCESS;
                end
            end
            ST_ACCESS:
            begin
                mem_we     = (op_reg.kind == OP_BUMP);
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            count_mem[mem_wa] <= mem_wd;
        end
        rd_data_reg <= count_mem[mem_ra];
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            op_reg <= q_head;
        end
        res_count_reg <= op_reg.in_range ? sat_count : '0;
        res_sym_reg   <= op_reg.symbol;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_addr_reg  <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            res_valid_reg <= (state_reg == ST_ACCESS) && (op_reg.kind == OP_READ);
            if (state_reg == ST_CLEAR)
            begin
                clr_addr_reg <= clr_addr_reg + AW'(1);
            end
        end
    end

endmodule
